FILE: design/osm_pkg.sv
// Shared types and constants of the order-statistic multiset.
// Depends on nothing; osm_walk and order_statistic_multiset refer to it by scoped names.
`default_nettype none

package osm_pkg;

    // Sizing of the value domain and of the per-node counters.
    localparam int VALUE_BITS = 10;
    localparam int COUNT_BITS = 17;
    localparam int ADDR_W     = VALUE_BITS + 1;
    localparam int NODE_SLOTS = 2 ** ADDR_W;
    localparam int OPND_W     = 16;
    localparam int ANS_W      = 17;
    localparam int K_W        = (COUNT_BITS > OPND_W) ? COUNT_BITS : OPND_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [ANS_W-1:0]      ANSWER_MAX = {ANS_W{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_KTH    = 2'd2,
        OP_RANK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_K_RANGE = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_KTH,
        S_RANK
    } t_state;

    // One accepted request as seen by the tree walker.
    typedef struct packed {
        logic              valid;
        logic [1:0]        op;
        logic [OPND_W-1:0] operand;
    } t_req;

    // Access to the node-count memory: one write and one read port.
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [COUNT_BITS-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

endpackage

`default_nettype wire

FILE: design/osm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module osm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/osm_walk.sv
// Tree walker: runs one request over the counting segment tree, a level per cycle.
// Depends on osm_pkg; drives the node-count memory through a t_mem_req struct.
`default_nettype none

module osm_walk (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire osm_pkg::t_req                   i_req,
    output logic                                 o_busy,
    output osm_pkg::t_mem_req                    o_mem,
    input  wire logic [osm_pkg::COUNT_BITS-1:0]  i_rdata,
    output logic                                 o_valid,
    output logic [osm_pkg::ANS_W-1:0]            o_answer,
    output logic [1:0]                           o_status
);

    osm_pkg::t_state r_state, n_state;
    logic [osm_pkg::ADDR_W-1:0]     r_node, n_node;
    logic [osm_pkg::K_W-1:0]        r_k, n_k;
    logic [osm_pkg::COUNT_BITS-1:0] r_acc, n_acc;
    logic [osm_pkg::COUNT_BITS-1:0] r_total, n_total;
    logic                           r_first, n_first;
    logic                           r_del, n_del;
    logic                           r_valid, n_valid;
    logic [osm_pkg::ANS_W-1:0]      r_answer, n_answer;
    osm_pkg::t_status               r_status, n_status;

    osm_pkg::t_op                   op;
    logic [osm_pkg::ADDR_W-1:0]     leaf;
    logic [osm_pkg::K_W-1:0]        k_in;
    logic                           kth_bad;
    logic                           full;
    logic                           absent;
    logic                           upd_top;
    logic                           left_ge;
    logic [osm_pkg::ADDR_W-1:0]     kth_next;
    logic                           kth_leaf;
    logic [osm_pkg::ADDR_W-1:0]     rank_next;
    logic                           rank_end;
    logic [osm_pkg::COUNT_BITS-1:0] acc_add;
    logic [32:0]                    rank_sum;
    logic [osm_pkg::ANS_W-1:0]      rank_ans;

    // Decode of the incoming request and of the current tree step.
    assign op       = osm_pkg::t_op'(i_req.op);
    assign leaf     = {1'b1, i_req.operand[osm_pkg::VALUE_BITS-1:0]};
    assign k_in     = osm_pkg::K_W'(i_req.operand);
    assign kth_bad  = (i_req.operand == '0) || (k_in > osm_pkg::K_W'(r_total));
    assign full     = (r_total == osm_pkg::COUNT_MAX);
    assign absent   = r_del && r_first && (i_rdata == '0);
    assign upd_top  = (r_node == osm_pkg::ADDR_W'(1));

    // Descent for the k-th smallest: go left when the left subtree holds k.
    assign left_ge  = (osm_pkg::K_W'(i_rdata) >= r_k);
    assign kth_next = {r_node[osm_pkg::VALUE_BITS-1:0], ~left_ge};
    assign kth_leaf = kth_next[osm_pkg::VALUE_BITS];

    // Ascent for the rank: a right child adds its left sibling's count.
    assign rank_next = r_node >> 1;
    assign rank_end  = (rank_next == osm_pkg::ADDR_W'(1));
    assign acc_add   = r_node[0] ? (r_acc + i_rdata) : r_acc;
    assign rank_sum  = 33'(acc_add) + 33'd1;
    assign rank_ans  = (rank_sum > 33'(osm_pkg::ANSWER_MAX)) ? osm_pkg::ANSWER_MAX
                                                            : rank_sum[osm_pkg::ANS_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            osm_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    case (op)
                        osm_pkg::OP_INSERT: n_state = full ? osm_pkg::S_IDLE : osm_pkg::S_UPD;
                        osm_pkg::OP_DELETE: n_state = osm_pkg::S_UPD;
                        osm_pkg::OP_KTH:    n_state = kth_bad ? osm_pkg::S_IDLE : osm_pkg::S_KTH;
                        default:            n_state = osm_pkg::S_RANK;
                    endcase
                end
            end
            osm_pkg::S_UPD: begin
                if (absent || upd_top) begin
                    n_state = osm_pkg::S_IDLE;
                end
            end
            osm_pkg::S_KTH: begin
                if (kth_leaf) begin
                    n_state = osm_pkg::S_IDLE;
                end
            end
            osm_pkg::S_RANK: begin
                if (rank_end) begin
                    n_state = osm_pkg::S_IDLE;
                end
            end
            default: n_state = osm_pkg::S_IDLE;
        endcase
    end

    // Memory accesses, datapath updates and result.
    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.waddr = r_node;
        o_mem.wdata = r_del ? (i_rdata - osm_pkg::COUNT_BITS'(1))
                            : (i_rdata + osm_pkg::COUNT_BITS'(1));
        o_mem.raddr = r_node >> 1;
        n_node      = r_node;
        n_k         = r_k;
        n_acc       = r_acc;
        n_total     = r_total;
        n_first     = r_first;
        n_del       = r_del;
        n_valid     = 1'b0;
        n_answer    = r_answer;
        n_status    = r_status;
        case (r_state)
            osm_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_first  = 1'b1;
                    n_del    = (op == osm_pkg::OP_DELETE);
                    n_answer = '0;
                    n_status = osm_pkg::ST_OK;
                    case (op)
                        osm_pkg::OP_INSERT, osm_pkg::OP_DELETE: begin
                            if ((op == osm_pkg::OP_INSERT) && full) begin
                                n_valid  = 1'b1;
                                n_status = osm_pkg::ST_FULL;
                            end else begin
                                o_mem.raddr = leaf;
                                n_node      = leaf;
                            end
                        end
                        osm_pkg::OP_KTH: begin
                            if (kth_bad) begin
                                n_valid  = 1'b1;
                                n_status = osm_pkg::ST_K_RANGE;
                            end else begin
                                n_node      = osm_pkg::ADDR_W'(1);
                                n_k         = k_in;
                                o_mem.raddr = osm_pkg::ADDR_W'(2);
                            end
                        end
                        default: begin
                            n_node      = leaf;
                            n_acc       = '0;
                            o_mem.raddr = leaf ^ osm_pkg::ADDR_W'(1);
                        end
                    endcase
                end
            end
            osm_pkg::S_UPD: begin
                // Read data is the count of r_node; write it back adjusted.
                if (absent) begin
                    n_valid  = 1'b1;
                    n_status = osm_pkg::ST_ABSENT;
                end else begin
                    o_mem.we = 1'b1;
                    n_first  = 1'b0;
                    if (upd_top) begin
                        n_total = o_mem.wdata;
                        n_valid = 1'b1;
                    end else begin
                        n_node      = r_node >> 1;
                        o_mem.raddr = r_node >> 1;
                    end
                end
            end
            osm_pkg::S_KTH: begin
                if (!left_ge) begin
                    n_k = r_k - osm_pkg::K_W'(i_rdata);
                end
                n_node      = kth_next;
                o_mem.raddr = {kth_next[osm_pkg::VALUE_BITS-1:0], 1'b0};
                if (kth_leaf) begin
                    n_valid  = 1'b1;
                    n_answer = osm_pkg::ANS_W'(kth_next[osm_pkg::VALUE_BITS-1:0]);
                end
            end
            osm_pkg::S_RANK: begin
                n_acc       = acc_add;
                n_node      = rank_next;
                o_mem.raddr = rank_next ^ osm_pkg::ADDR_W'(1);
                if (rank_end) begin
                    n_valid  = 1'b1;
                    n_answer = rank_ans;
                end
            end
            default: ;
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osm_pkg::S_IDLE;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_k      <= n_k;
        r_acc    <= n_acc;
        r_first  <= n_first;
        r_del    <= n_del;
        r_answer <= n_answer;
        r_status <= n_status;
    end

    assign o_busy   = (r_state != osm_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_answer = r_answer;
    assign o_status = r_status;

    // Requests only arrive while the walker is idle.
    a_req_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> (r_state == osm_pkg::S_IDLE))
        else $error("request taken while walker busy");

    // A result is always delivered with the walker back in idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == osm_pkg::S_IDLE))
        else $error("result strobe while walk in progress");

    // The descent stays on internal nodes and k never drops to zero.
    a_kth_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osm_pkg::S_KTH) |-> (!r_node[osm_pkg::VALUE_BITS] && (r_k != '0)))
        else $error("k-th descent left the internal nodes or lost k");

    // The total register follows every root write.
    a_total_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && (o_mem.waddr == osm_pkg::ADDR_W'(1))) |=>
            (r_total == $past(o_mem.wdata)))
        else $error("total out of step with root count");

endmodule

`default_nettype wire

FILE: design/order_statistic_multiset.sv
// Order-statistic multiset: insert, delete, k-th smallest and rank over 2^VALUE_BITS values.
// Each request walks the tree with one memory access per tree level, and o_valid strobes
// its result; a flagged request (full insert, k out of range, absent delete) returns early.
// A new start is not taken while a walk runs, but is taken in the cycle the strobe shows.
// After reset busy stays high while all 2^(VALUE_BITS+1) store entries are cleared.
// Depends on osm_pkg, osm_ram and osm_walk; the receiver cannot stall.
`default_nettype none

module order_statistic_multiset (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic [1:0]                   i_operation,
    input  wire logic [osm_pkg::OPND_W-1:0]   i_operand,
    output logic                              busy,
    output logic                              o_valid,
    output logic [osm_pkg::ANS_W-1:0]         o_answer,
    output logic [1:0]                        o_status
);

    logic                           r_clr_active;
    logic [osm_pkg::ADDR_W-1:0]     r_clr_addr;
    logic                           walk_busy;
    osm_pkg::t_req                  req;
    osm_pkg::t_mem_req              walk_mem;
    osm_pkg::t_mem_req              mem;
    logic [osm_pkg::COUNT_BITS-1:0] rdata;

    // Clearing pass after reset: one entry a cycle over the whole store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + osm_pkg::ADDR_W'(1);
            if (r_clr_addr == '1) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Request handshake.
    assign busy        = r_clr_active || walk_busy;
    assign req.valid   = start && !busy;
    assign req.op      = i_operation;
    assign req.operand = i_operand;

    // The clearing pass owns the write port until it finishes.
    always_comb begin
        mem = walk_mem;
        if (r_clr_active) begin
            mem.we    = 1'b1;
            mem.waddr = r_clr_addr;
            mem.wdata = '0;
        end
    end

    osm_ram #(
        .WIDTH (osm_pkg::COUNT_BITS),
        .DEPTH (osm_pkg::NODE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    osm_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_busy   (walk_busy),
        .o_mem    (walk_mem),
        .i_rdata  (rdata),
        .o_valid  (o_valid),
        .o_answer (o_answer),
        .o_status (o_status)
    );

endmodule

`default_nettype wire
